>>> sv/pidr_pkg.sv
package pidr_pkg;

    // field and register widths
    localparam int ValW   = 32;  // Q16.16 values
    localparam int GainW  = 24;  // Q8.16 gains
    localparam int LimW   = 31;  // limit and ramp rate
    localparam int DtW    = 16;  // Q0.16 step time
    localparam int IntW   = 48;  // integrator
    localparam int CfgIdxW = 3;

    // shared multiplier: signed A times unsigned B
    localparam int MulAW  = 41;
    localparam int MulBW  = GainW;
    localparam int ProdW  = MulAW + MulBW + 1;

    // derivative divider: |kd * delta_err| < 2^56
    localparam int DivW   = 56;
    localparam int CntW   = 6;

    localparam int InDataW  = 2 * ValW + DtW;
    localparam int SumW     = DivW + 2;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_PROP_GAIN     = 3'd0,
        CFG_INTEGRAL_GAIN = 3'd1,
        CFG_DERIV_GAIN    = 3'd2,
        CFG_DRIVE_LIMIT   = 3'd3,
        CFG_RAMP_RATE     = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RAMP_MUL,
        ST_RAMP,
        ST_ERR,
        ST_P_MUL,
        ST_I_MUL,
        ST_INC_MUL,
        ST_D_MUL,
        ST_DIV_SETUP,
        ST_DIV,
        ST_NEG,
        ST_SUM,
        ST_CLIP,
        ST_DONE
    } pidr_state_t;

endpackage

>>> sv/pid_with_setpoint_ramp_core.sv
// PID controller with setpoint slew limiting and clamping anti-windup, all in
// Q16.16 fixed point. Each input item carries target, measurement and step
// time (Q0.16 s). Each one produces exactly one output item holding the drive
// and a clamped flag. A zero step time returns the previous drive with the
// flag clear and leaves all state untouched, going straight to the done
// state. A normal item first does the ramp, the error and five products on
// one shared signed 41 by unsigned 24 bit multiplier (ramp step, P, I, I
// times dt, D). A setup state then prepares a 56-step restoring divider,
// which divides the derivative product by the step time, one quotient bit
// per cycle; the first normal item after reset skips it, with no derivative.
// Then come the sign, the add, the clip and the output load. The input is
// not ready while an item is in flight, so a new item is not taken before
// the last one is loaded into the output register. The result sits in an
// output register, so the next item is accepted as soon as the block
// returns idle. A result still held in that register holds the block in its
// done state until the register drains. Gains and limits are to be written on
// the cfg port only while the block is idle; the user is bound to this, as
// the block does not enforce it. Writes to indexes above 4 are ignored.
module pid_with_setpoint_ramp_core (
    input  logic                            clk,
    input  logic                            rst_n,
    // config write port
    input  logic                            cfg_we,
    input  logic [pidr_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [pidr_pkg::LimW-1:0]       cfg_data,
    // input items
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [pidr_pkg::InDataW-1:0]    s_axis_tdata,  // target, measurement, step_time
    // result items
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [pidr_pkg::ValW-1:0]       m_axis_tdata,  // drive
    output logic                            m_axis_tuser   // clamped
);
    import pidr_pkg::*;

    pidr_state_t state_reg, state_next;

    // config
    logic [GainW-1:0] kp_reg, kp_next, ki_reg, ki_next, kd_reg, kd_next;
    logic [LimW-1:0]  lim_reg, lim_next, rate_reg, rate_next;

    // controller state
    logic signed [ValW-1:0] rt_reg, rt_next;
    logic signed [IntW-1:0] int_reg, int_next;
    logic signed [ValW-1:0] prev_reg, prev_next;
    logic signed [ValW-1:0] last_reg, last_next;
    logic                   first_reg, first_next;

    // per-item working registers
    logic signed [ValW-1:0]   tgt_reg, tgt_next, meas_reg, meas_next;
    logic [DtW-1:0]           dt_reg, dt_next;
    logic signed [ProdW-1:0]  prod_reg, prod_next;
    logic signed [ValW-1:0]   err_reg, err_next;
    logic signed [ValW:0]     diff_reg, diff_next;
    logic signed [39:0]       p_reg, p_next;
    logic signed [IntW-1:0]   newint_reg, newint_next;
    logic signed [IntW:0]     pi_reg, pi_next;
    logic                     neg_reg, neg_next;
    logic [DivW-1:0]          dvd_reg, dvd_next;
    logic [DtW-1:0]           rem_reg, rem_next;
    logic [CntW-1:0]          cnt_reg, cnt_next;
    logic signed [DivW:0]     d_reg, d_next;
    logic signed [SumW-1:0]   sum_reg, sum_next;
    logic [ValW-1:0]          res_drive_reg, res_drive_next;
    logic                     res_clip_reg, res_clip_next;

    // output slot
    logic                     out_valid_reg, out_valid_next;
    logic [ValW-1:0]          out_drive_reg, out_drive_next;
    logic                     out_clip_reg, out_clip_next;

    // shared multiplier
    logic signed [MulAW-1:0]  mul_a;
    logic [MulBW-1:0]         mul_b;
    logic signed [MulBW:0]    mul_bs;
    logic signed [ProdW-1:0]  mul_full;

    // datapath temporaries
    logic [LimW-1:0]          slew_step;
    logic signed [ValW:0]     mc33, ramp_err, rt_wide, e33;
    logic signed [39:0]       inc;
    logic signed [IntW:0]     int_sum49;
    logic signed [ProdW-1:0]  prod_abs;
    logic [DtW:0]             trial;
    logic                     q_bit;
    logic signed [SumW-1:0]   lim_s;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_RAMP_MUL:
            begin
                mul_a = MulAW'({1'b0, rate_reg});
                mul_b = MulBW'(dt_reg);
            end
            ST_P_MUL:
            begin
                mul_a = MulAW'(err_reg);
                mul_b = kp_reg;
            end
            ST_I_MUL:
            begin
                mul_a = MulAW'(err_reg);
                mul_b = ki_reg;
            end
            ST_INC_MUL:
            begin
                // floor(ki * err / 2^16), kept signed
                mul_a = MulAW'($signed(prod_reg[55:16]));
                mul_b = MulBW'(dt_reg);
            end
            ST_D_MUL:
            begin
                mul_a = MulAW'(diff_reg);
                mul_b = kd_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_bs   = $signed({1'b0, mul_b});
        mul_full = mul_a * mul_bs;
    end

    always_comb
    begin
        state_next     = state_reg;
        kp_next        = kp_reg;
        ki_next        = ki_reg;
        kd_next        = kd_reg;
        lim_next       = lim_reg;
        rate_next      = rate_reg;
        rt_next        = rt_reg;
        int_next       = int_reg;
        prev_next      = prev_reg;
        last_next      = last_reg;
        first_next     = first_reg;
        tgt_next       = tgt_reg;
        meas_next      = meas_reg;
        dt_next        = dt_reg;
        prod_next      = prod_reg;
        err_next       = err_reg;
        diff_next      = diff_reg;
        p_next         = p_reg;
        newint_next    = newint_reg;
        pi_next        = pi_reg;
        neg_next       = neg_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        d_next         = d_reg;
        sum_next       = sum_reg;
        res_drive_next = res_drive_reg;
        res_clip_next  = res_clip_reg;
        out_valid_next = out_valid_reg;
        out_drive_next = out_drive_reg;
        out_clip_next  = out_clip_reg;
        s_axis_tready  = 1'b0;

        slew_step  = prod_reg[46:16];
        mc33       = $signed({2'b00, slew_step});
        ramp_err   = $signed({tgt_reg[ValW-1], tgt_reg}) - $signed({rt_reg[ValW-1], rt_reg});
        rt_wide    = $signed({rt_reg[ValW-1], rt_reg});
        e33        = rt_wide - $signed({meas_reg[ValW-1], meas_reg});
        inc        = prod_reg[55:16];
        int_sum49  = (IntW+1)'(int_reg) + (IntW+1)'(inc);
        prod_abs   = prod_reg[ProdW-1] ? -prod_reg : prod_reg;
        trial      = {rem_reg, dvd_reg[DivW-1]};
        q_bit      = trial >= {1'b0, dt_reg};
        lim_s      = $signed(SumW'(lim_reg));

        // output slot drains independently of the sequencer
        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_PROP_GAIN:     kp_next   = cfg_data[GainW-1:0];
                CFG_INTEGRAL_GAIN: ki_next   = cfg_data[GainW-1:0];
                CFG_DERIV_GAIN:    kd_next   = cfg_data[GainW-1:0];
                CFG_DRIVE_LIMIT:   lim_next  = cfg_data;
                CFG_RAMP_RATE:     rate_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    tgt_next  = s_axis_tdata[ValW-1:0];
                    meas_next = s_axis_tdata[2*ValW-1:ValW];
                    dt_next   = s_axis_tdata[InDataW-1:2*ValW];
                    if (s_axis_tdata[InDataW-1:2*ValW] == '0)
                    begin
                        // hold: repeat last drive, no state change
                        res_drive_next = last_reg;
                        res_clip_next  = 1'b0;
                        state_next     = ST_DONE;
                    end
                    else
                        state_next = ST_RAMP_MUL;
                end
            end
            ST_RAMP_MUL:
            begin
                prod_next = mul_full;
                if (first_reg)
                    rt_next = meas_reg;
                state_next = ST_RAMP;
            end
            ST_RAMP:
            begin
                if (ramp_err > mc33)
                    rt_next = ValW'(rt_wide + mc33);
                else if (ramp_err < -mc33)
                    rt_next = ValW'(rt_wide - mc33);
                else
                    rt_next = tgt_reg;
                state_next = ST_ERR;
            end
            ST_ERR:
            begin
                if (e33[ValW] != e33[ValW-1])
                    err_next = e33[ValW] ? {1'b1, {(ValW-1){1'b0}}} : {1'b0, {(ValW-1){1'b1}}};
                else
                    err_next = e33[ValW-1:0];
                state_next = ST_P_MUL;
            end
            ST_P_MUL:
            begin
                prod_next  = mul_full;
                diff_next  = $signed({err_reg[ValW-1], err_reg})
                           - $signed({prev_reg[ValW-1], prev_reg});
                state_next = ST_I_MUL;
            end
            ST_I_MUL:
            begin
                p_next     = prod_reg[55:16];
                prod_next  = mul_full;
                state_next = ST_INC_MUL;
            end
            ST_INC_MUL:
            begin
                prod_next  = mul_full;
                state_next = ST_D_MUL;
            end
            ST_D_MUL:
            begin
                if (int_sum49[IntW] != int_sum49[IntW-1])
                    newint_next = int_sum49[IntW] ? {1'b1, {(IntW-1){1'b0}}}
                                                  : {1'b0, {(IntW-1){1'b1}}};
                else
                    newint_next = int_sum49[IntW-1:0];
                prod_next  = mul_full;
                state_next = ST_DIV_SETUP;
            end
            ST_DIV_SETUP:
            begin
                pi_next  = (IntW+1)'(p_reg) + (IntW+1)'(newint_reg);
                rem_next = '0;
                cnt_next = CntW'(DivW);
                if (first_reg)
                begin
                    // no derivative on the first run
                    neg_next   = 1'b0;
                    dvd_next   = '0;
                    state_next = ST_NEG;
                end
                else
                begin
                    neg_next   = prod_reg[ProdW-1];
                    dvd_next   = prod_abs[DivW-1:0];
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = q_bit ? DtW'(trial - {1'b0, dt_reg}) : trial[DtW-1:0];
                dvd_next = {dvd_reg[DivW-2:0], q_bit};
                cnt_next = cnt_reg - CntW'(1);
                if (cnt_reg == CntW'(1))
                    state_next = ST_NEG;
            end
            ST_NEG:
            begin
                d_next     = neg_reg ? -$signed({1'b0, dvd_reg}) : $signed({1'b0, dvd_reg});
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                sum_next   = SumW'(pi_reg) + SumW'(d_reg);
                state_next = ST_CLIP;
            end
            ST_CLIP:
            begin
                if (sum_reg > lim_s)
                begin
                    res_drive_next = {1'b0, lim_reg};
                    res_clip_next  = 1'b1;
                end
                else if (sum_reg < -lim_s)
                begin
                    res_drive_next = -{1'b0, lim_reg};
                    res_clip_next  = 1'b1;
                end
                else
                begin
                    res_drive_next = sum_reg[ValW-1:0];
                    res_clip_next  = 1'b0;
                    int_next       = newint_reg;  // anti-windup: keep only when unclipped
                end
                if (sum_reg > lim_s)
                    last_next = {1'b0, lim_reg};
                else if (sum_reg < -lim_s)
                    last_next = -{1'b0, lim_reg};
                else
                    last_next = sum_reg[ValW-1:0];
                prev_next  = err_reg;
                first_next = 1'b0;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_drive_next = res_drive_reg;
                    out_clip_next  = res_clip_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            kp_reg        <= '0;
            ki_reg        <= '0;
            kd_reg        <= '0;
            lim_reg       <= '1;
            rate_reg      <= '1;
            rt_reg        <= '0;
            int_reg       <= '0;
            prev_reg      <= '0;
            last_reg      <= '0;
            first_reg     <= 1'b1;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            kp_reg        <= kp_next;
            ki_reg        <= ki_next;
            kd_reg        <= kd_next;
            lim_reg       <= lim_next;
            rate_reg      <= rate_next;
            rt_reg        <= rt_next;
            int_reg       <= int_next;
            prev_reg      <= prev_next;
            last_reg      <= last_next;
            first_reg     <= first_next;
            cnt_reg       <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        tgt_reg       <= tgt_next;
        meas_reg      <= meas_next;
        dt_reg        <= dt_next;
        prod_reg      <= prod_next;
        err_reg       <= err_next;
        diff_reg      <= diff_next;
        p_reg         <= p_next;
        newint_reg    <= newint_next;
        pi_reg        <= pi_next;
        neg_reg       <= neg_next;
        dvd_reg       <= dvd_next;
        rem_reg       <= rem_next;
        d_reg         <= d_next;
        sum_reg       <= sum_next;
        res_drive_reg <= res_drive_next;
        res_clip_reg  <= res_clip_next;
        out_drive_reg <= out_drive_next;
        out_clip_reg  <= out_clip_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_drive_reg;
    assign m_axis_tuser  = out_clip_reg;

endmodule
